// File: design/moving_average_filter_defines.svh
// Assertion macros shared by the filter RTL.
`ifndef MOVING_AVERAGE_FILTER_DEFINES_SVH
`define MOVING_AVERAGE_FILTER_DEFINES_SVH

`ifndef SYNTHESIS
`define MAF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("moving average filter check failed");
`define MAF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("moving average filter check failed");
`else
`define MAF_ASSERT_SAME(label, ante, cons)
`define MAF_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: design/maf_pkg.sv
package maf_pkg;

    localparam int RING_DEPTH   = 32;
    localparam int SAMPLE_WIDTH = 16;

    localparam int SLOT_WIDTH  = $clog2(RING_DEPTH);
    localparam int LEN_WIDTH   = $clog2(RING_DEPTH + 1);
    localparam int SUM_WIDTH   = SAMPLE_WIDTH + SLOT_WIDTH;
    localparam int COUNT_WIDTH = $clog2(SUM_WIDTH);

    localparam int CFG_WIDTH   = 6;
    localparam int ADDR_WIDTH  = 3;
    localparam int DATA_WIDTH  = 32;
    localparam int TDATA_WIDTH = ((SAMPLE_WIDTH + 7) / 8) * 8;

    localparam logic [CFG_WIDTH-1:0] WINDOW_LENGTH_RESET = CFG_WIDTH'(10);
    localparam logic [0:0]           REG_WINDOW_LENGTH   = 1'b0;

endpackage

// File: design/moving_average_filter.sv
// Boxcar moving average over the last window_length samples.
// An accepted sample goes through the update state, the bit-serial divider (21 steps) and
// the done state; s_tready is high only in idle, so one sample is in flight at a time.
// Reset (rst_n, asynchronous, active low) sets window_length to 10 and clears the
// sum, the write slot and the ring valid bits; a window_length write clears them too.
`include "moving_average_filter_defines.svh"

module moving_average_filter
(
    input  logic                              clk,
    input  logic                              rst_n,
    // s_tdata fields from bit 0: sample
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [maf_pkg::TDATA_WIDTH-1:0]   s_tdata,
    // m_tdata fields from bit 0: mean
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [maf_pkg::TDATA_WIDTH-1:0]   m_tdata,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [maf_pkg::ADDR_WIDTH-1:0]    paddr,
    input  logic [maf_pkg::DATA_WIDTH-1:0]    pwdata,
    output logic [maf_pkg::DATA_WIDTH-1:0]    prdata,
    output logic                              pready
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_UPDATE = 2'd1;
    localparam logic [1:0] ST_DIV    = 2'd2;
    localparam logic [1:0] ST_DONE   = 2'd3;

    localparam int SW = maf_pkg::SAMPLE_WIDTH;
    localparam int UW = maf_pkg::SUM_WIDTH;
    localparam int LW = maf_pkg::LEN_WIDTH;
    localparam int PW = maf_pkg::SLOT_WIDTH;
    localparam int CW = maf_pkg::COUNT_WIDTH;

    logic [1:0]                      state_reg, state_next;
    logic [maf_pkg::CFG_WIDTH-1:0]   window_length_reg, window_length_next;
    logic [PW-1:0]                   write_slot_reg, write_slot_next;
    logic signed [UW-1:0]            window_sum_reg, window_sum_next;
    logic [maf_pkg::RING_DEPTH-1:0]  ring_valid_reg, ring_valid_next;
    logic signed [SW-1:0]            sample_reg, sample_next;
    logic [UW-1:0]                   quo_reg, quo_next;
    logic [LW-1:0]                   rem_reg, rem_next;
    logic [CW-1:0]                   count_reg, count_next;
    logic                            neg_reg, neg_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    logic [SW-1:0]                   mean_reg, mean_next;

    logic signed [SW-1:0]            ring_mem [maf_pkg::RING_DEPTH];
    logic signed [SW-1:0]            ring_rd_reg;
    logic                            rd_valid_reg;

    logic                            cfg_write;
    logic                            in_accept;
    logic [LW-1:0]                   eff_len;
    logic [PW-1:0]                   cur_slot;
    logic [LW-1:0]                   slot_plus;
    logic signed [SW-1:0]            old_sample;
    logic [LW:0]                     trial;
    logic [UW-1:0]                   quo_signed;

    assign pready    = 1'b1;
    assign prdata    = maf_pkg::DATA_WIDTH'(window_length_reg);
    assign cfg_write = psel && penable && pwrite && (paddr[2] == maf_pkg::REG_WINDOW_LENGTH);
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = maf_pkg::TDATA_WIDTH'(mean_reg);

    always_comb
    begin
        if (window_length_reg == '0)
        begin
            eff_len = LW'(1);
        end
        else if (32'(window_length_reg) > 32'(maf_pkg::RING_DEPTH))
        begin
            eff_len = LW'(maf_pkg::RING_DEPTH);
        end
        else
        begin
            eff_len = LW'(window_length_reg);
        end
    end

    assign cur_slot   = (LW'(write_slot_reg) >= eff_len) ? '0 : write_slot_reg;
    assign slot_plus  = LW'(write_slot_reg) + LW'(1);
    assign old_sample = rd_valid_reg ? ring_rd_reg : '0;
    assign trial      = {rem_reg, quo_reg[UW-1]};
    assign quo_signed = neg_reg ? (~quo_reg + UW'(1)) : quo_reg;

    always_comb
    begin
        state_next         = state_reg;
        window_length_next = window_length_reg;
        write_slot_next    = write_slot_reg;
        window_sum_next    = window_sum_reg;
        ring_valid_next    = ring_valid_reg;
        sample_next        = sample_reg;
        quo_next           = quo_reg;
        rem_next           = rem_reg;
        count_next         = count_reg;
        neg_next           = neg_reg;
        m_tvalid_next      = m_tvalid_reg;
        mean_next          = mean_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    sample_next     = s_tdata[SW-1:0];
                    write_slot_next = cur_slot;
                    state_next      = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                window_sum_next = window_sum_reg - UW'(old_sample) + UW'(sample_reg);
                ring_valid_next[write_slot_reg] = 1'b1;
                write_slot_next = (slot_plus >= eff_len) ? '0 : slot_plus[PW-1:0];
                neg_next   = window_sum_next[UW-1];
                quo_next   = window_sum_next[UW-1] ? (~window_sum_next + UW'(1))
                                                   : window_sum_next;
                rem_next   = '0;
                count_next = CW'(UW - 1);
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (trial >= {1'b0, eff_len})
                begin
                    rem_next = LW'(trial - {1'b0, eff_len});
                    quo_next = {quo_reg[UW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[LW-1:0];
                    quo_next = {quo_reg[UW-2:0], 1'b0};
                end
                count_next = count_reg - CW'(1);
                if (count_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    mean_next     = quo_signed[SW-1:0];
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_write)
        begin
            window_length_next = pwdata[maf_pkg::CFG_WIDTH-1:0];
            ring_valid_next    = '0;
            write_slot_next    = '0;
            window_sum_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            window_length_reg <= maf_pkg::WINDOW_LENGTH_RESET;
            write_slot_reg    <= '0;
            window_sum_reg    <= '0;
            ring_valid_reg    <= '0;
            m_tvalid_reg      <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            window_length_reg <= window_length_next;
            write_slot_reg    <= write_slot_next;
            window_sum_reg    <= window_sum_next;
            ring_valid_reg    <= ring_valid_next;
            m_tvalid_reg      <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        count_reg  <= count_next;
        neg_reg    <= neg_next;
        mean_reg   <= mean_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            ring_rd_reg  <= ring_mem[cur_slot];
            rd_valid_reg <= ring_valid_reg[cur_slot];
        end
        if (state_reg == ST_UPDATE)
        begin
            ring_mem[write_slot_reg] <= sample_reg;
        end
    end

    `MAF_ASSERT_NEXT(a_accept_to_update, in_accept && !cfg_write, state_reg == ST_UPDATE)
    `MAF_ASSERT_SAME(a_rem_below_len, state_reg == ST_DIV, rem_reg < eff_len)
    `MAF_ASSERT_NEXT(a_done_loads_out, (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready),
                     m_tvalid && (state_reg == ST_IDLE))

endmodule

// File: sim/tb_moving_average_filter.sv
module tb_moving_average_filter;

    localparam logic [maf_pkg::ADDR_WIDTH-1:0] WINDOW_ADDR =
        maf_pkg::ADDR_WIDTH'(maf_pkg::REG_WINDOW_LENGTH) << 2;
    localparam logic [maf_pkg::ADDR_WIDTH-1:0] UNUSED_ADDR = maf_pkg::ADDR_WIDTH'(4);
    localparam int STALL_LIMIT = 3000;
    localparam logic [maf_pkg::SAMPLE_WIDTH-1:0] SAMPLE_MAX =
        {1'b0, {(maf_pkg::SAMPLE_WIDTH-1){1'b1}}};
    localparam logic [maf_pkg::SAMPLE_WIDTH-1:0] SAMPLE_MIN =
        {1'b1, {(maf_pkg::SAMPLE_WIDTH-1){1'b0}}};

    logic                                clk;
    logic                                rst_n;
    logic                                s_tvalid;
    logic                                s_tready;
    logic [maf_pkg::TDATA_WIDTH-1:0]     s_tdata;
    logic                                m_tvalid;
    logic                                m_tready;
    logic [maf_pkg::TDATA_WIDTH-1:0]     m_tdata;
    logic                                psel;
    logic                                penable;
    logic                                pwrite;
    logic [maf_pkg::ADDR_WIDTH-1:0]      paddr;
    logic [maf_pkg::DATA_WIDTH-1:0]      pwdata;
    logic [maf_pkg::DATA_WIDTH-1:0]      prdata;
    logic                                pready;

    logic [maf_pkg::SAMPLE_WIDTH-1:0]        pending_samples[$];
    logic [maf_pkg::SAMPLE_WIDTH-1:0]        expected_means[$];
    logic signed [maf_pkg::SAMPLE_WIDTH-1:0] history[maf_pkg::RING_DEPTH];
    int                                      next_slot;
    longint                                  running_total;
    logic [maf_pkg::CFG_WIDTH-1:0]           window_setting;
    int                                      mismatches;
    int                                      send_gap;
    int                                      recv_stall;
    int                                      quiet_cycles;
    bit                                      bursty;

    moving_average_filter DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function void clear_history();
        for (int i = 0; i < maf_pkg::RING_DEPTH; i++)
        begin
            history[i] = '0;
        end
        next_slot     = 0;
        running_total = 0;
    endfunction

    function int active_window();
        int n;
        n = window_setting;
        if (n == 0)
        begin
            n = 1;
        end
        if (n > maf_pkg::RING_DEPTH)
        begin
            n = maf_pkg::RING_DEPTH;
        end
        return n;
    endfunction

    function void predict_mean(input logic signed [maf_pkg::SAMPLE_WIDTH-1:0] sample);
        int     len;
        longint avg;
        len = active_window();
        if (next_slot >= len)
        begin
            next_slot = 0;
        end
        running_total = running_total - history[next_slot] + sample;
        history[next_slot] = sample;
        next_slot++;
        if (next_slot >= len)
        begin
            next_slot = 0;
        end
        avg = running_total / len;
        expected_means.push_back(avg[maf_pkg::SAMPLE_WIDTH-1:0]);
    endfunction

    function void report_mismatch(input string what,
                                  input logic [maf_pkg::DATA_WIDTH-1:0] want,
                                  input logic [maf_pkg::DATA_WIDTH-1:0] got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("Mismatch on %s: expected %0h, got %0h", what, want, got);
        end
    endfunction

    // Sample driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            send_gap = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_mean(s_tdata[maf_pkg::SAMPLE_WIDTH-1:0]);
            end
            if (s_tvalid && !s_tready)
            begin
                s_tvalid <= 1'b1;
            end
            else if (send_gap > 0)
            begin
                send_gap--;
                s_tvalid <= 1'b0;
            end
            else if (bursty && $urandom_range(0, 9) == 0)
            begin
                send_gap = $urandom_range(0, 14);
                s_tvalid <= 1'b0;
            end
            else if (pending_samples.size() > 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= maf_pkg::TDATA_WIDTH'(pending_samples.pop_front());
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Mean monitor.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            recv_stall = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_means.size() == 0)
                begin
                    report_mismatch("unexpected mean", '0, maf_pkg::DATA_WIDTH'(m_tdata));
                end
                else
                begin
                    logic [maf_pkg::SAMPLE_WIDTH-1:0] want;
                    want = expected_means.pop_front();
                    if (m_tdata[maf_pkg::SAMPLE_WIDTH-1:0] !== want)
                    begin
                        report_mismatch("mean", maf_pkg::DATA_WIDTH'(want),
                                        maf_pkg::DATA_WIDTH'(m_tdata));
                    end
                end
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                m_tready <= 1'b0;
            end
            else if (bursty && $urandom_range(0, 9) == 0)
            begin
                recv_stall = $urandom_range(0, 14);
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task apb_write(input logic [maf_pkg::ADDR_WIDTH-1:0] addr,
                   input logic [maf_pkg::DATA_WIDTH-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        if (addr == WINDOW_ADDR)
        begin
            window_setting = data[maf_pkg::CFG_WIDTH-1:0];
            clear_history();
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task apb_read_check();
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= WINDOW_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        if (prdata !== maf_pkg::DATA_WIDTH'(window_setting))
        begin
            report_mismatch("window_length read", maf_pkg::DATA_WIDTH'(window_setting), prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task wait_drained();
        while (pending_samples.size() > 0 || s_tvalid || expected_means.size() > 0)
        begin
            @(posedge clk);
        end
    endtask

    // A phase opens with a run of one extreme value long enough to fill the window,
    // then mixes extremes, small values and full-range random samples.
    task queue_phase(input int count);
        logic [maf_pkg::SAMPLE_WIDTH-1:0] level;
        int                               run;
        level = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
        run   = active_window() + 2;
        for (int i = 0; i < count; i++)
        begin
            if (i < run)
            begin
                pending_samples.push_back(level);
            end
            else
            begin
                case ($urandom_range(0, 7))
                    0: pending_samples.push_back(SAMPLE_MAX);
                    1: pending_samples.push_back(SAMPLE_MIN);
                    2: pending_samples.push_back(
                           maf_pkg::SAMPLE_WIDTH'($urandom_range(0, 15)));
                    3: pending_samples.push_back(
                           -maf_pkg::SAMPLE_WIDTH'($urandom_range(0, 15)));
                    default: pending_samples.push_back(maf_pkg::SAMPLE_WIDTH'($urandom));
                endcase
            end
        end
    endtask

    initial
    begin
        logic [maf_pkg::DATA_WIDTH-1:0] settings[$];
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        mismatches     = 0;
        bursty         = 1'b1;
        window_setting = maf_pkg::WINDOW_LENGTH_RESET;
        clear_history();
        settings = '{1, 32, 0, 63, 33, 2, 32'h0000_0145, 17, 31, 16, 7, $urandom_range(0, 63)};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Default window, zero-filled start, then both extremes held across the window.
        pending_samples.push_back(16'sd0);
        pending_samples.push_back(16'sd1);
        pending_samples.push_back(-16'sd1);
        repeat (11) pending_samples.push_back(SAMPLE_MAX);
        repeat (11) pending_samples.push_back(SAMPLE_MIN);
        wait_drained();
        apb_read_check();

        foreach (settings[i])
        begin
            if (i == settings.size() - 1)
            begin
                bursty = 1'b0;
            end
            apb_write(WINDOW_ADDR, settings[i]);
            apb_read_check();
            if (i == 5)
            begin
                // Writes outside the register map must leave the window untouched.
                apb_write(UNUSED_ADDR, 32'd3);
                apb_read_check();
            end
            queue_phase(52);
            wait_drained();
        end

        repeat (40) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
